// File: hdl/ftr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftr_pkg
// Types and codes shared by the frame and tile transfer receiver.
// ----------------------------------------------------------------------------
package ftr_pkg;

  // message codes on the input channel
  typedef enum logic [3:0] {
    OP_BEGIN      = 4'd0,
    OP_END        = 4'd1,
    OP_STOP       = 4'd2,
    OP_HELLO      = 4'd3,
    OP_TILE_BEGIN = 4'd4,
    OP_TILE_END   = 4'd5,
    OP_VIEW       = 4'd6,
    OP_CHUNK      = 4'd7,
    OP_DONE       = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_IMAGE  = 3'd1,
    EV_TILE   = 3'd2,
    EV_VIEW   = 3'd3,
    EV_STOP   = 3'd4,
    EV_QUERY  = 3'd5,
    EV_REFUSE = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    WHY_PARAM = 2'd0,
    WHY_BUSY  = 2'd1,
    WHY_TRUNC = 2'd2
  } reason_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RECV   = 3'b010,
    ST_DECODE = 3'b100
  } rx_state_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_MAX_BYTES     = 2'd2,
    REG_MAX_ZOOM      = 2'd3
  } reg_index_t;

  localparam int CFG_DATA_BITS = 25;

  localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd800;
  localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd480;
  localparam logic [24:0] MAX_BYTES_RESET     = 25'd262144;
  localparam logic [4:0]  MAX_ZOOM_RESET      = 5'd22;

  // shortest accepted begin, end, tile begin and view messages, in bytes
  localparam logic [9:0] LEN_BEGIN      = 10'(1 + 2 + 2 + 4 + 2);
  localparam logic [9:0] LEN_END        = 10'(1 + 2);
  localparam logic [9:0] LEN_TILE_BEGIN = 10'(1 + 1 + 1 + 4 + 4 + 4 + 2);
  localparam logic [9:0] LEN_VIEW       = 10'(1 + 4 + 4 + 1 + 2);

  // frame dimensions must be whole blocks of 2**BLOCK_BITS (16) pixels
  localparam int BLOCK_BITS = 4;

  typedef struct packed {
    logic [3:0]  operation;
    logic [9:0]  msg_len;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] total_bytes;
    logic [15:0] seq_in;
    logic [7:0]  zoom;
    logic [7:0]  tile_format;
    logic [31:0] tile_x;
    logic [31:0] tile_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] event_seq;
    logic [1:0]  reject_reason;
    logic        length_matches;
    logic [24:0] received_count;
    logic [23:0] write_offset;
    logic        write_enable;
    logic [31:0] dim_or_x;
    logic [31:0] dim_or_y;
    logic [7:0]  format_out;
    logic [4:0]  zoom_out;
  } out_item_t;

endpackage
`default_nettype wire

// File: hdl/frame_transfer_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Latency: a result is valid the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless out_ready stalls; the transfer
// state is updated in a single pass at the accepting edge and the result waits
// in one output register. Reset clears the transfer state to idle, drops any held
// result and restores panel size, byte limit and zoom limit to their reset values.
// ----------------------------------------------------------------------------
// frame_transfer_receiver_top
// Receive-side controller for chunked frame and tile transfers.
// ----------------------------------------------------------------------------
module frame_transfer_receiver_top #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire ftr_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output ftr_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [ftr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int CW = COUNT_BITS + 1;  // count width
  localparam int SW = COUNT_BITS + 2;  // count plus chunk length
  localparam logic [32:0] SIZE_CAP = 33'(1) << COUNT_BITS;

  // configuration
  logic [11:0] screen_width;
  logic [11:0] screen_height;
  logic [24:0] max_frame_bytes;
  logic [4:0]  max_zoom;

  // transfer state
  ftr_pkg::rx_state_t st, st_next;
  logic [CW-1:0] expected, expected_next;
  logic [CW-1:0] received, received_next;
  logic [15:0]   open_seq, open_seq_next;
  logic          open_is_tile, open_is_tile_next;
  logic [11:0]   frame_w, frame_w_next;
  logic [11:0]   frame_h, frame_h_next;
  logic [7:0]    held_format, held_format_next;
  logic [4:0]    held_zoom, held_zoom_next;
  logic [31:0]   held_x, held_x_next;
  logic [31:0]   held_y, held_y_next;

  ftr_pkg::out_item_t res_next;

  logic in_fire;
  logic [32:0] size_limit;
  logic [SW-1:0] chunk_sum;
  logic [32:0] recv_wide;
  logic [27:0] w_cross;
  logic [27:0] h_cross;
  logic frame_bad;
  logic tile_bad;
  logic want_tile;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width    <= ftr_pkg::SCREEN_WIDTH_RESET;
      screen_height   <= ftr_pkg::SCREEN_HEIGHT_RESET;
      max_frame_bytes <= ftr_pkg::MAX_BYTES_RESET;
      max_zoom        <= ftr_pkg::MAX_ZOOM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ftr_pkg::REG_SCREEN_WIDTH:  screen_width    <= cfg_data[11:0];
        ftr_pkg::REG_SCREEN_HEIGHT: screen_height   <= cfg_data[11:0];
        ftr_pkg::REG_MAX_BYTES:     max_frame_bytes <= cfg_data[24:0];
        ftr_pkg::REG_MAX_ZOOM:      max_zoom        <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // begin checks
  assign size_limit = (33'(max_frame_bytes) < SIZE_CAP) ? 33'(max_frame_bytes) : SIZE_CAP;
  assign w_cross    = 28'(in_data.width) * 28'(screen_height);
  assign h_cross    = 28'(in_data.height) * 28'(screen_width);

  assign frame_bad = (in_data.total_bytes == 32'd0)
                  || (33'(in_data.total_bytes) > size_limit)
                  || (in_data.width == 16'd0) || (in_data.height == 16'd0)
                  || (in_data.width > 16'(screen_width))
                  || (in_data.height > 16'(screen_height))
                  || (in_data.width[ftr_pkg::BLOCK_BITS-1:0] != '0)
                  || (in_data.height[ftr_pkg::BLOCK_BITS-1:0] != '0)
                  || (w_cross != h_cross);

  assign tile_bad = (in_data.total_bytes == 32'd0)
                 || (33'(in_data.total_bytes) > size_limit)
                 || (in_data.zoom > 8'(max_zoom));

  assign chunk_sum = SW'(received) + SW'(in_data.msg_len);
  assign want_tile = (in_data.operation == ftr_pkg::OP_TILE_END);

  always_comb begin
    st_next           = st;
    expected_next     = expected;
    received_next     = received;
    open_seq_next     = open_seq;
    open_is_tile_next = open_is_tile;
    frame_w_next      = frame_w;
    frame_h_next      = frame_h;
    held_format_next  = held_format;
    held_zoom_next    = held_zoom;
    held_x_next       = held_x;
    held_y_next       = held_y;
    res_next          = '0;
    recv_wide         = 33'(received);

    case (in_data.operation)
      ftr_pkg::OP_CHUNK: begin
        if (st == ftr_pkg::ST_RECV && in_data.msg_len != 10'd0) begin
          if (chunk_sum > SW'(expected)) begin
            // overrun: drop the data, mark one past expected
            received_next = expected + CW'(1);
          end else begin
            res_next.write_offset = recv_wide[23:0];
            res_next.write_enable = 1'b1;
            received_next         = chunk_sum[CW-1:0];
          end
          recv_wide               = 33'(received_next);
          res_next.received_count = recv_wide[24:0];
        end
      end
      ftr_pkg::OP_DONE: begin
        if (st == ftr_pkg::ST_DECODE) begin
          st_next = ftr_pkg::ST_IDLE;
        end
      end
      ftr_pkg::OP_BEGIN, ftr_pkg::OP_TILE_BEGIN: begin
        if (in_data.msg_len != 10'd0) begin
          if (in_data.msg_len < ((in_data.operation == ftr_pkg::OP_BEGIN) ?
                                 ftr_pkg::LEN_BEGIN : ftr_pkg::LEN_TILE_BEGIN)) begin
            st_next                = ftr_pkg::ST_IDLE;
            res_next.event_kind    = ftr_pkg::EV_REFUSE;
            res_next.reject_reason = ftr_pkg::WHY_PARAM;
          end else if (st == ftr_pkg::ST_DECODE) begin
            st_next                = ftr_pkg::ST_IDLE;
            res_next.event_kind    = ftr_pkg::EV_REFUSE;
            res_next.event_seq     = in_data.seq_in;
            res_next.reject_reason = ftr_pkg::WHY_BUSY;
          end else if ((in_data.operation == ftr_pkg::OP_BEGIN) ? frame_bad : tile_bad) begin
            st_next                = ftr_pkg::ST_IDLE;
            res_next.event_kind    = ftr_pkg::EV_REFUSE;
            res_next.event_seq     = in_data.seq_in;
            res_next.reject_reason = ftr_pkg::WHY_PARAM;
          end else begin
            // open the transfer, dropping any one in progress
            expected_next = CW'(in_data.total_bytes);
            received_next = '0;
            open_seq_next = in_data.seq_in;
            st_next       = ftr_pkg::ST_RECV;
            if (in_data.operation == ftr_pkg::OP_BEGIN) begin
              open_is_tile_next = 1'b0;
              frame_w_next      = in_data.width[11:0];
              frame_h_next      = in_data.height[11:0];
            end else begin
              open_is_tile_next = 1'b1;
              held_format_next  = in_data.tile_format;
              held_zoom_next    = in_data.zoom[4:0];
              held_x_next       = in_data.tile_x;
              held_y_next       = in_data.tile_y;
            end
          end
        end
      end
      ftr_pkg::OP_END, ftr_pkg::OP_TILE_END: begin
        if (in_data.msg_len >= ftr_pkg::LEN_END) begin
          if (st != ftr_pkg::ST_RECV || in_data.seq_in != open_seq
              || open_is_tile != want_tile) begin
            st_next                = ftr_pkg::ST_IDLE;
            res_next.event_kind    = ftr_pkg::EV_REFUSE;
            res_next.event_seq     = in_data.seq_in;
            res_next.reject_reason = ftr_pkg::WHY_TRUNC;
          end else begin
            st_next                 = ftr_pkg::ST_DECODE;
            res_next.event_seq      = in_data.seq_in;
            res_next.length_matches = (received == expected);
            res_next.received_count = recv_wide[24:0];
            if (want_tile) begin
              res_next.event_kind = ftr_pkg::EV_TILE;
              res_next.dim_or_x   = held_x;
              res_next.dim_or_y   = held_y;
              res_next.format_out = held_format;
              res_next.zoom_out   = held_zoom;
            end else begin
              res_next.event_kind = ftr_pkg::EV_IMAGE;
              res_next.dim_or_x   = 32'(frame_w);
              res_next.dim_or_y   = 32'(frame_h);
            end
          end
        end
      end
      ftr_pkg::OP_VIEW: begin
        if (in_data.msg_len >= ftr_pkg::LEN_VIEW && in_data.zoom <= 8'(max_zoom)) begin
          res_next.event_kind = ftr_pkg::EV_VIEW;
        end
      end
      ftr_pkg::OP_STOP: begin
        if (in_data.msg_len != 10'd0) begin
          st_next             = ftr_pkg::ST_IDLE;
          res_next.event_kind = ftr_pkg::EV_STOP;
        end
      end
      ftr_pkg::OP_HELLO: begin
        if (in_data.msg_len != 10'd0) begin
          res_next.event_kind = ftr_pkg::EV_QUERY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ftr_pkg::ST_IDLE;
      expected     <= '0;
      received     <= '0;
      open_seq     <= '0;
      open_is_tile <= 1'b0;
      frame_w      <= '0;
      frame_h      <= '0;
      held_format  <= '0;
      held_zoom    <= '0;
      held_x       <= '0;
      held_y       <= '0;
    end else if (in_fire) begin
      st           <= st_next;
      expected     <= expected_next;
      received     <= received_next;
      open_seq     <= open_seq_next;
      open_is_tile <= open_is_tile_next;
      frame_w      <= frame_w_next;
      frame_h      <= frame_h_next;
      held_format  <= held_format_next;
      held_zoom    <= held_zoom_next;
      held_x       <= held_x_next;
      held_y       <= held_y_next;
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= res_next;
    end
  end

  // received count never passes the one-past-expected overrun mark
  assert property (@(posedge clk) disable iff (rst)
    SW'(received) <= SW'(expected) + SW'(1))
    else $error("received count beyond overrun mark");

  // a ready event moves the transfer to decoding
  assert property (@(posedge clk) disable iff (rst)
    in_fire && (res_next.event_kind == ftr_pkg::EV_IMAGE
                || res_next.event_kind == ftr_pkg::EV_TILE)
    |=> st == ftr_pkg::ST_DECODE)
    else $error("ready event did not enter decoding");

  // every reject returns to idle
  assert property (@(posedge clk) disable iff (rst)
    in_fire && res_next.event_kind == ftr_pkg::EV_REFUSE |=> st == ftr_pkg::ST_IDLE)
    else $error("reject did not return to idle");

  // a buffer write only comes with a chunk, never with an event
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.write_enable |-> out_data.event_kind == ftr_pkg::EV_NONE)
    else $error("write enable alongside an event");

endmodule
`default_nettype wire
